[src/lcdcs_pkg.sv]
// ----------------------------------------------------------------------------
// LCD 4-bit command sequencer package
// Request codes, queue entry and pulse types, delay constants and the
// power-up pulse table shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdcs_pkg;

  localparam int DefRows    = 2;
  localparam int DefColumns = 16;

  // request codes
  typedef enum logic [2:0] {
    MODE_INIT  = 3'd0,
    MODE_DATA  = 3'd1,
    MODE_CMD   = 3'd2,
    MODE_CLEAR = 3'd3,
    MODE_GOTO  = 3'd4
  } mode_e;

  localparam logic [7:0] ClearCmd   = 8'h01;
  localparam logic [7:0] GotoCmd    = 8'h80;
  localparam logic [7:0] Line2Ofs   = 8'h40;

  localparam logic [12:0] SettleUs   = 13'd50;
  localparam logic [12:0] ByteTailUs = 13'd2000;
  localparam logic [12:0] ClearTail  = 13'd3000;
  localparam logic [12:0] InitTail   = 13'd2000;
  localparam logic [15:0] PowerUpUs  = 16'd50000;
  localparam logic [15:0] SetupUs    = 16'd1;

  localparam logic [3:0] InitLastStep = 4'd11;

  // queue depth between front and back end
  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);

  // one classified request
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic       clr;
    logic [7:0] data;
  } cmd_t;

  // one enable pulse
  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] lead_us;
    logic [12:0] wait_us;
    logic        last;
  } pulse_t;

  function automatic pulse_t mk_pulse(input logic rs, input logic [3:0] nib,
                                      input logic [15:0] lead,
                                      input logic [12:0] wt, input logic lst);
    pulse_t p;
    p.reg_select = rs;
    p.nibble     = nib;
    p.lead_us    = lead;
    p.wait_us    = wt;
    p.last       = lst;
    return p;
  endfunction

  // power-up run: reset nibbles, then 0x28, 0x0C, 0x01, 0x06 as byte pairs
  function automatic pulse_t init_pulse(input logic [3:0] step);
    pulse_t p;
    case (step)
      4'd0:    p = mk_pulse(1'b0, 4'h3, PowerUpUs, SettleUs + 13'd5000, 1'b0);
      4'd1:    p = mk_pulse(1'b0, 4'h3, 16'd0, SettleUs + 13'd150, 1'b0);
      4'd2:    p = mk_pulse(1'b0, 4'h3, 16'd0, SettleUs + 13'd150, 1'b0);
      4'd3:    p = mk_pulse(1'b0, 4'h2, 16'd0, SettleUs + 13'd2000, 1'b0);
      4'd4:    p = mk_pulse(1'b0, 4'h2, SetupUs, SettleUs, 1'b0);
      4'd5:    p = mk_pulse(1'b0, 4'h8, 16'd0, SettleUs + ByteTailUs + InitTail, 1'b0);
      4'd6:    p = mk_pulse(1'b0, 4'h0, SetupUs, SettleUs, 1'b0);
      4'd7:    p = mk_pulse(1'b0, 4'hC, 16'd0, SettleUs + ByteTailUs + InitTail, 1'b0);
      4'd8:    p = mk_pulse(1'b0, 4'h0, SetupUs, SettleUs, 1'b0);
      4'd9:    p = mk_pulse(1'b0, 4'h1, 16'd0, SettleUs + ByteTailUs + ClearTail, 1'b0);
      4'd10:   p = mk_pulse(1'b0, 4'h0, SetupUs, SettleUs, 1'b0);
      4'd11:   p = mk_pulse(1'b0, 4'h6, 16'd0, SettleUs + ByteTailUs + InitTail, 1'b1);
      default: p = mk_pulse(1'b0, 4'h0, 16'd0, 13'd0, 1'b1);
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[src/lcdcs_front.sv]
// ----------------------------------------------------------------------------
// LCD sequencer front end
// Registers each request, reduces row and column by reciprocal multiply,
// and classifies it into a queue entry. Unused codes are dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdcs_front #(
  parameter int ROWS    = lcdcs_pkg::DefRows,
  parameter int COLUMNS = lcdcs_pkg::DefColumns
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        mode_i,
  input  wire logic [7:0]        value_i,
  input  wire logic [7:0]        row_i,
  input  wire logic [7:0]        col_i,
  output logic                   push_o,
  output lcdcs_pkg::cmd_t        push_data_o,
  input  wire logic              full_i
);
  import lcdcs_pkg::*;

  localparam int QShift   = 16;
  localparam int RowRecip = (1 << QShift) / ROWS + 1;
  localparam int ColRecip = (1 << QShift) / COLUMNS + 1;
  localparam int ColW     = $clog2(COLUMNS);
  localparam int RowW     = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [24:0] row_prod, col_prod;
  logic        s_valid_q;
  logic [2:0]  mode_q;
  logic [7:0]  value_q, row_q, col_q, row_quo_q, col_quo_q;
  logic [7:0]  row_rem, col_rem, line_base, addr_sum;
  logic [1:0]  row_sel;
  logic        mode_ok, advance, accept;
  cmd_t        cmd;

  // floor(x / C) for 8-bit x: reciprocal error stays below 1/C
  assign row_prod = 25'(row_i) * 25'(RowRecip);
  assign col_prod = 25'(col_i) * 25'(ColRecip);

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (advance) begin
      s_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= mode_i;
      value_q   <= value_i;
      row_q     <= row_i;
      col_q     <= col_i;
      row_quo_q <= row_prod[QShift +: 8];
      col_quo_q <= col_prod[QShift +: 8];
    end
  end

  assign row_rem   = 8'(row_q - 8'(row_quo_q * 8'(ROWS)));
  assign col_rem   = 8'(col_q - 8'(col_quo_q * 8'(COLUMNS)));
  assign row_sel   = 2'(row_rem[RowW-1:0]);
  assign line_base = (row_sel[0] ? Line2Ofs : 8'h00) + (row_sel[1] ? 8'(COLUMNS) : 8'h00);
  assign addr_sum  = line_base + 8'(col_rem[ColW-1:0]);

  always_comb begin
    cmd     = '0;
    mode_ok = 1'b1;
    case (mode_e'(mode_q))
      MODE_INIT:  cmd.is_init = 1'b1;
      MODE_DATA: begin
        cmd.rs   = 1'b1;
        cmd.data = value_q;
      end
      MODE_CMD:   cmd.data = value_q;
      MODE_CLEAR: begin
        cmd.data = ClearCmd;
        cmd.clr  = 1'b1;
      end
      MODE_GOTO:  cmd.data = GotoCmd | {1'b0, addr_sum[6:0]};
      default:    mode_ok = 1'b0;
    endcase
  end

  assign push_o      = s_valid_q && mode_ok && !full_i;
  assign push_data_o = cmd;
  // stage empties when it pushes or holds a dropped code
  assign advance     = !s_valid_q || !mode_ok || !full_i;
  assign in_stall_o  = !advance;

endmodule

`default_nettype wire

[src/lcdcs_fifo.sv]
// ----------------------------------------------------------------------------
// LCD sequencer command queue
// Short register queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdcs_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lcdcs_pkg::cmd_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output lcdcs_pkg::cmd_t      head_o,
  output logic                 empty_o
);
  import lcdcs_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAw:0]     cnt_q;

  assign full_o  = (cnt_q == (QAw+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

[src/lcdcs_back.sv]
// ----------------------------------------------------------------------------
// LCD sequencer back end
// Expands the queue head into enable pulses, one per cycle unless stalled,
// into an output register. Bytes give two pulses, power-up gives twelve.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdcs_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lcdcs_pkg::cmd_t head_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output lcdcs_pkg::pulse_t    pulse_o
);
  import lcdcs_pkg::*;

  logic [3:0] step_q;
  logic       ov_q;
  pulse_t     pulse_q, cur;
  logic       load;

  always_comb begin
    if (head_i.is_init) begin
      cur = init_pulse(step_q);
    end else if (!step_q[0]) begin
      cur = mk_pulse(head_i.rs, head_i.data[7:4], SetupUs, SettleUs, 1'b0);
    end else begin
      cur = mk_pulse(head_i.rs, head_i.data[3:0], 16'd0,
                     SettleUs + ByteTailUs + (head_i.clr ? ClearTail : 13'd0), 1'b1);
    end
  end

  assign load  = !empty_i && (!ov_q || !out_stall_i);
  assign pop_o = load && cur.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      step_q <= '0;
    end else begin
      if (load) begin
        ov_q   <= 1'b1;
        step_q <= cur.last ? 4'd0 : step_q + 4'd1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) pulse_q <= cur;
  end

  assign out_valid_o = ov_q;
  assign pulse_o     = pulse_q;

endmodule

`default_nettype wire

[src/lcd_4bit_command_sequencer_top.sv]
// ----------------------------------------------------------------------------
// LCD 4-bit command sequencer
// Turns requests (power-up, data, command, clear, go-to) into enable
// pulses for a character LCD on a 4-bit bus.
// ----------------------------------------------------------------------------
// channel  | direction | handshake               | payload
// request  | in        | in_valid_i / in_stall_o | mode_i value_i row_i col_i
// pulse    | out       | out_valid_o/out_stall_i | reg_select_o nibble_o lead_us_o
//          |           |                         | wait_us_o last_o
//
// A byte request gives the back end two pulses (one pulse per cycle out of
// the output register while out_stall_i is low); power-up gives it twelve.
// The first pulse of a request passes the input stage, the queue write and
// the output register in that order. Unused mode codes give no pulses.
// rst_ni clears all valid state and the pulse counter asynchronously.
// out_stall_i holds the output register; the queue absorbs the front end.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_4bit_command_sequencer_top #(
  parameter int ROWS    = lcdcs_pkg::DefRows,
  parameter int COLUMNS = lcdcs_pkg::DefColumns
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [7:0]  value_i,
  input  wire logic [7:0]  row_i,
  input  wire logic [7:0]  col_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             reg_select_o,
  output logic [3:0]       nibble_o,
  output logic [15:0]      lead_us_o,
  output logic [12:0]      wait_us_o,
  output logic             last_o
);
  import lcdcs_pkg::*;

  cmd_t   push_data, head;
  pulse_t pulse;
  logic   push, full, pop, empty;

  lcdcs_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  lcdcs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  lcdcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pulse_o     (pulse)
  );

  assign reg_select_o = pulse.reg_select;
  assign nibble_o     = pulse.nibble;
  assign lead_us_o    = pulse.lead_us;
  assign wait_us_o    = pulse.wait_us;
  assign last_o       = pulse.last;

endmodule

`default_nettype wire

[src/lcdcs_checker.sv]
// ----------------------------------------------------------------------------
// LCD sequencer port checker
// Watches the top-level ports for output handshake rules and pulse shapes.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdcs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        reg_select_o,
  input wire logic [3:0]  nibble_o,
  input wire logic [15:0] lead_us_o,
  input wire logic [12:0] wait_us_o,
  input wire logic        last_o
);

  // a stalled pulse stays up
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("pulse dropped while stalled");

  // and keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(nibble_o) && $stable(wait_us_o)
      && $stable(lead_us_o) && $stable(last_o) && $stable(reg_select_o))
    else $error("pulse payload changed while stalled");

  // the closing pulse of a request is always a low nibble: no lead time
  a_last_no_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> lead_us_o == 16'd0)
    else $error("closing pulse carries lead time");

  // the power-up wait only ever comes with a command-mode 0x3 nibble
  a_powerup_nibble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lead_us_o == 16'd50000 |-> nibble_o == 4'h3 && !reg_select_o && !last_o)
    else $error("power-up wait on wrong pulse");

  // data pulses settle 50 us, or 2050 us after the low nibble
  a_data_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reg_select_o |-> wait_us_o == 13'd50 || wait_us_o == 13'd2050)
    else $error("data pulse with unexpected wait");

endmodule

bind lcd_4bit_command_sequencer_top lcdcs_checker u_lcdcs_checker (.*);

`default_nettype wire

[tb/lcd_4bit_command_sequencer_top_test.sv]
// ----------------------------------------------------------------------------
// LCD 4-bit command sequencer testbench
// Drives power-up, data, command, clear, go-to and unused requests. Each
// taken request is expanded here into its expected enable pulses, and each
// pulse out of the block is checked field by field. Both sides idle and stall
// at random. One phase has a long receiver hold-off, one has no idling at all.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_4bit_command_sequencer_top_test;
  import lcdcs_pkg::*;

  localparam logic [2:0]  ModeSpareLo   = 3'd5;
  localparam logic [2:0]  ModeSpareHi   = 3'd7;
  localparam int          Rows          = 2;
  localparam int          Columns       = 16;
  localparam logic [12:0] SettleWaitUs  = 13'd50;
  localparam logic [12:0] ByteExtraUs   = 13'd2000;
  localparam logic [12:0] ClearExtraUs  = 13'd3000;
  localparam logic [12:0] InitExtraUs   = 13'd2000;
  localparam logic [15:0] PowerUpLeadUs = 16'd50000;
  localparam logic [15:0] ByteLeadUs    = 16'd1;
  localparam logic [7:0]  ClearByte     = 8'h01;
  localparam logic [7:0]  SetAddrByte   = 8'h80;
  localparam logic [6:0]  AddrMask      = 7'h7F;
  localparam int          StallLimit    = 3000;
  localparam int          TailCycles    = 20;
  localparam int          HoldOffCycles = 80;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] value;
    logic [7:0] row;
    logic [7:0] col;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  mode = '0;
  logic [7:0]  value = '0;
  logic [7:0]  row = '0;
  logic [7:0]  col = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [15:0] lead_us;
  logic [12:0] wait_us;
  logic        last;

  request_t request_q[$];
  pulse_t   pulse_q[$];

  int  send_idle_pct = 24;
  int  recv_idle_pct = 24;
  int  hold_off_left = 0;
  bit  req_taken = 1'b0;
  int  n_queued = 0;
  int  n_taken = 0;
  int  n_power_up = 0;
  int  n_ignored = 0;
  int  n_pulses = 0;
  int  n_errors = 0;
  int  quiet_cycles = 0;

  lcd_4bit_command_sequencer_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .mode_i       (mode),
    .value_i      (value),
    .row_i        (row),
    .col_i        (col),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .reg_select_o (reg_select),
    .nibble_o     (nibble),
    .lead_us_o    (lead_us),
    .wait_us_o    (wait_us),
    .last_o       (last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic add_pulse(input logic rs, input logic [3:0] nib, input logic [15:0] lead,
                           input logic [12:0] wt, input logic lst);
    pulse_t p;
    p.reg_select = rs;
    p.nibble     = nib;
    p.lead_us    = lead;
    p.wait_us    = wt;
    p.last       = lst;
    pulse_q.push_back(p);
  endtask

  // high nibble first; extra delay goes after the low nibble
  task automatic add_byte(input logic rs, input logic [7:0] b, input logic [12:0] extra,
                          input logic lst);
    add_pulse(rs, b[7:4], ByteLeadUs, SettleWaitUs, 1'b0);
    add_pulse(rs, b[3:0], 16'd0, SettleWaitUs + ByteExtraUs + extra, lst);
  endtask

  task automatic expand_request(input request_t r);
    logic [7:0] line_ofs;
    logic [6:0] addr;
    case (r.mode)
      MODE_INIT: begin
        add_pulse(1'b0, 4'h3, PowerUpLeadUs, SettleWaitUs + 13'd5000, 1'b0);
        add_pulse(1'b0, 4'h3, 16'd0, SettleWaitUs + 13'd150, 1'b0);
        add_pulse(1'b0, 4'h3, 16'd0, SettleWaitUs + 13'd150, 1'b0);
        add_pulse(1'b0, 4'h2, 16'd0, SettleWaitUs + 13'd2000, 1'b0);
        add_byte(1'b0, 8'h28, InitExtraUs, 1'b0);
        add_byte(1'b0, 8'h0C, InitExtraUs, 1'b0);
        add_byte(1'b0, ClearByte, ClearExtraUs, 1'b0);
        add_byte(1'b0, 8'h06, InitExtraUs, 1'b1);
        n_power_up++;
      end
      MODE_DATA:  add_byte(1'b1, r.value, 13'd0, 1'b1);
      MODE_CMD:   add_byte(1'b0, r.value, 13'd0, 1'b1);
      MODE_CLEAR: add_byte(1'b0, ClearByte, ClearExtraUs, 1'b1);
      MODE_GOTO: begin
        case (int'(r.row) % Rows)
          0:       line_ofs = 8'h00;
          1:       line_ofs = 8'h40;
          2:       line_ofs = 8'(Columns);
          default: line_ofs = 8'h40 + 8'(Columns);
        endcase
        addr = 7'(line_ofs + 8'(int'(r.col) % Columns)) & AddrMask;
        add_byte(1'b0, SetAddrByte | {1'b0, addr}, 13'd0, 1'b1);
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic queue_request(input logic [2:0] m, input logic [7:0] v, input logic [7:0] r,
                               input logic [7:0] c);
    request_t req;
    req.mode  = m;
    req.value = v;
    req.row   = r;
    req.col   = c;
    request_q.push_back(req);
    n_queued++;
  endtask

  // power-up kept rare; a few spare codes mixed in as noise
  task automatic queue_random(input int n);
    int   done;
    int   pick;
    logic [2:0] m;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      if (pick < 3)       m = MODE_INIT;
      else if (pick < 33) m = MODE_DATA;
      else if (pick < 55) m = MODE_CMD;
      else if (pick < 65) m = MODE_CLEAR;
      else if (pick < 94) m = MODE_GOTO;
      else                m = 3'($urandom_range(ModeSpareHi, ModeSpareLo));
      queue_request(m, 8'($urandom), 8'($urandom), 8'($urandom));
      if (m <= MODE_GOTO) done++;
    end
  endtask

  task automatic wait_taken();
    while (n_taken != n_queued) @(posedge clk_i);
  endtask

  task automatic drain();
    wait_taken();
    while (pulse_q.size() != 0) @(posedge clk_i);
  endtask

  // request side: predict on every taken item
  always @(posedge clk_i) begin
    request_t r;
    if (rst_ni && in_valid && !in_stall) begin
      r.mode  = mode;
      r.value = value;
      r.row   = row;
      r.col   = col;
      expand_request(r);
      req_taken = 1'b1;
      n_taken++;
    end
  end

  always @(negedge clk_i) begin
    request_t nxt;
    if (rst_ni && (!in_valid || req_taken)) begin
      req_taken = 1'b0;
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = request_q.pop_front();
        in_valid <= 1'b1;
        mode     <= nxt.mode;
        value    <= nxt.value;
        row      <= nxt.row;
        col      <= nxt.col;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    pulse_t e;
    if (rst_ni && out_valid && !out_stall) begin
      n_pulses++;
      if (pulse_q.size() == 0) begin
        $error("pulse with nothing expected: nibble 0x%0h last %0b", nibble, last);
        n_errors++;
      end else begin
        e = pulse_q.pop_front();
        check_field("reg_select", e.reg_select, reg_select);
        check_field("nibble", e.nibble, nibble);
        check_field("lead_us", e.lead_us, lead_us);
        check_field("wait_us", e.wait_us, wait_us);
        check_field("last", e.last, last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: %0d cycles without progress", quiet_cycles);
        $display("lcd_4bit_command_sequencer_top_test: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: every request kind, field extremes, row/column wrap, spare codes
    queue_request(MODE_INIT, 8'hFF, 8'hFF, 8'hFF);
    queue_request(MODE_DATA, 8'h00, 8'hFF, 8'hFF);
    queue_request(MODE_DATA, 8'hFF, 8'h00, 8'h00);
    queue_request(MODE_DATA, 8'hA5, 8'h5A, 8'hC3);
    queue_request(MODE_CMD, 8'h00, 8'hFF, 8'hFF);
    queue_request(MODE_CMD, 8'hFF, 8'h00, 8'h00);
    queue_request(MODE_CMD, 8'h5A, 8'hA5, 8'h3C);
    queue_request(MODE_CLEAR, 8'hFF, 8'hFF, 8'hFF);
    queue_request(MODE_CLEAR, 8'h00, 8'h00, 8'h00);
    queue_request(MODE_GOTO, 8'hFF, 8'd0, 8'd0);
    queue_request(MODE_GOTO, 8'h00, 8'd1, 8'd15);
    queue_request(MODE_GOTO, 8'h00, 8'd2, 8'd16);
    queue_request(MODE_GOTO, 8'h00, 8'd3, 8'd31);
    queue_request(MODE_GOTO, 8'h00, 8'd255, 8'd255);
    queue_request(MODE_GOTO, 8'h00, 8'd254, 8'd128);
    queue_request(ModeSpareLo, 8'hFF, 8'hFF, 8'hFF);
    queue_request(3'd6, 8'h00, 8'h00, 8'h00);
    queue_request(ModeSpareHi, 8'hA5, 8'h5A, 8'h0F);
    queue_request(MODE_INIT, 8'h00, 8'h00, 8'h00);
    queue_request(MODE_DATA, 8'h41, 8'h00, 8'h00);

    queue_random(150);
    // sender waits until every pulse is out
    drain();
    repeat (5) @(posedge clk_i);

    // receiver holds off while the sender keeps offering
    send_idle_pct = 0;
    hold_off_left = HoldOffCycles;
    queue_random(40);
    wait_taken();
    send_idle_pct = 24;

    // no idling on either side
    drain();
    recv_idle_pct = 0;
    send_idle_pct = 0;
    queue_random(140);
    wait_taken();

    recv_idle_pct = 24;
    send_idle_pct = 24;
    queue_random(130);

    drain();
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d requests (%0d power-up runs, %0d spare codes), %0d pulses checked",
             n_taken, n_power_up, n_ignored, n_pulses);
    $display("phases: idle/stall mix, long receiver hold-off, back-to-back with no gaps");
    if (n_errors == 0 && pulse_q.size() == 0) begin
      $display("lcd_4bit_command_sequencer_top_test: clean");
    end else begin
      if (pulse_q.size() != 0) $error("%0d expected pulses never came", pulse_q.size());
      $display("lcd_4bit_command_sequencer_top_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
